/* sv/csp_pkg.sv */
`timescale 1ns / 1ps

package csp_pkg;

  localparam int NAME_COUNT = 20;
  localparam int NAME_MAX_LEN = 7;
  localparam int ROM_DEPTH = 8;
  localparam int POS_W = 4;

  localparam logic [POS_W-1:0] POS_LIMIT = 4'd8;
  localparam logic [POS_W-1:0] LEN_SHORT_HEX = 4'd4;
  localparam logic [POS_W-1:0] LEN_LONG_HEX = 4'd7;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef struct packed {
    logic [POS_W-1:0]      pos;
    logic                  hex;
    logic [23:0]           digits;
    logic                  err;
    logic [NAME_COUNT-1:0] match;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [31:0] rgba;
  } result_t;

  localparam state_t STATE_RESET = '{
    pos:    '0,
    hex:    1'b0,
    digits: '0,
    err:    1'b0,
    match:  {NAME_COUNT{1'b1}}
  };

  localparam logic [7:0] NAME_ROM [NAME_COUNT][ROM_DEPTH] = '{
    '{"a", "q", "u", "a", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "l", "a", "c", "k", 8'h00, 8'h00, 8'h00},
    '{"b", "l", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "y", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "u", "c", "h", "s", "i", "a", 8'h00},
    '{"g", "r", "a", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "e", "n", 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "i", "m", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "a", "g", "e", "n", "t", "a", 8'h00},
    '{"m", "a", "r", "o", "o", "n", 8'h00, 8'h00},
    '{"n", "a", "v", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "l", "i", "v", "e", 8'h00, 8'h00, 8'h00},
    '{"o", "r", "a", "n", "g", "e", 8'h00, 8'h00},
    '{"p", "u", "r", "p", "l", "e", 8'h00, 8'h00},
    '{"r", "e", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "i", "l", "v", "e", "r", 8'h00, 8'h00},
    '{"t", "e", "a", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "t", "e", 8'h00, 8'h00, 8'h00},
    '{"y", "e", "l", "l", "o", "w", 8'h00, 8'h00}
  };

  localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd7, 4'd4, 4'd5, 4'd4, 4'd4, 4'd7,
    4'd6, 4'd4, 4'd5, 4'd6, 4'd6, 4'd3, 4'd6, 4'd4, 4'd5, 4'd6
  };

  // {blue, green, red}
  localparam logic [23:0] NAME_BGR [NAME_COUNT] = '{
    24'hFFFF00, 24'h000000, 24'hFF0000, 24'hFFFF00, 24'hFF00FF,
    24'h808080, 24'h008000, 24'h808080, 24'h00FF00, 24'hFF00FF,
    24'h000080, 24'h800000, 24'h008080, 24'h00A5FF, 24'h800080,
    24'h0000FF, 24'hC0C0C0, 24'h808000, 24'hFFFFFF, 24'h00FFFF
  };

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= "0" && c <= "9") begin
      v = {1'b0, c[3:0]};
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      v = 5'd9 + {2'b00, c[2:0]};
    end
    return v;
  endfunction

endpackage

/* sv/csp_step.sv */
`timescale 1ns / 1ps

module csp_step (
  input  csp_pkg::state_t  state_i,
  input  logic [7:0]       char_i,
  input  logic             last_i,
  input  logic             empty_i,
  output csp_pkg::state_t  state_o,
  output csp_pkg::result_t result_o
);
  import csp_pkg::*;

  state_t      nxt;
  logic [7:0]  lc;
  logic [4:0]  hv;
  logic        ok;
  logic [23:0] bgr;

  always_comb begin
    lc = (char_i >= "A" && char_i <= "Z") ? char_i + CASE_OFFSET : char_i;
    hv = hex_value(char_i);

    nxt = state_i;
    if (state_i.pos == '0 && char_i == CHAR_HASH) begin
      nxt.hex = 1'b1;
    end else if (state_i.hex) begin
      if (hv[4]) begin
        nxt.err = 1'b1;
      end
      nxt.digits = {state_i.digits[19:0], hv[3:0]};
    end

    for (int i = 0; i < NAME_COUNT; i++) begin
      if (state_i.match[i] && (state_i.pos >= NAME_LEN[i] ||
          lc != NAME_ROM[i][state_i.pos[2:0]])) begin
        nxt.match[i] = 1'b0;
      end
    end

    nxt.pos = (state_i.pos >= POS_LIMIT - 4'd1) ? POS_LIMIT : state_i.pos + 4'd1;

    ok  = 1'b0;
    bgr = '0;
    if (nxt.hex) begin
      if (!nxt.err && nxt.pos == LEN_SHORT_HEX) begin
        ok  = 1'b1;
        bgr = {nxt.digits[3:0], nxt.digits[3:0], nxt.digits[7:4], nxt.digits[7:4],
               nxt.digits[11:8], nxt.digits[11:8]};
      end else if (!nxt.err && nxt.pos == LEN_LONG_HEX) begin
        ok  = 1'b1;
        bgr = {nxt.digits[7:0], nxt.digits[15:8], nxt.digits[23:16]};
      end
    end else begin
      for (int i = NAME_COUNT - 1; i >= 0; i--) begin
        if (nxt.match[i] && nxt.pos == NAME_LEN[i]) begin
          ok  = 1'b1;
          bgr = NAME_BGR[i];
        end
      end
    end

    result_o.valid = empty_i | last_i;
    result_o.ok    = ok & ~empty_i;
    result_o.rgba  = (ok && !empty_i) ? {ALPHA_OPAQUE, bgr} : 32'd0;

    state_o = (empty_i || last_i) ? STATE_RESET : nxt;
  end

endmodule

/* sv/color_string_parser_unit.sv */
`timescale 1ns / 1ps
// Channel  Dir  tdata                 tlast      tuser
// s_axis   in   [7:0] character       last_char  no_char
// m_axis   out  [31:0] rgba           -          parse_ok
//
// One character per cycle is accepted unless a stalled result holds a full
// input register; the result word is registered: the input register takes
// the character that ends the string, then the character step writes the
// result register.
// Reset clears both valid flags and returns the parse state to its start.
// A stalled result holds the result register; the input register still
// drains into the state as long as the result register is free.

module color_string_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] character
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tuser_i,   // [0] no_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] rgba
  output logic        m_axis_tuser_o    // [0] parse_ok
);
  import csp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_last_q;
  logic        in_empty_q;
  state_t      state_q, state_d;
  result_t     res;
  logic        out_valid_q;
  logic [31:0] out_rgba_q;
  logic        out_ok_q;
  logic        out_free;
  logic        advance;

  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign advance         = in_valid_q & out_free;
  assign s_axis_tready_o = ~in_valid_q | out_free;

  csp_step u_step (
    .state_i  (state_q),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .empty_i  (in_empty_q),
    .state_o  (state_d),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= advance & res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q  <= s_axis_tdata_i;
      in_last_q  <= s_axis_tlast_i;
      in_empty_q <= s_axis_tuser_i;
    end
    if (advance && res.valid) begin
      out_rgba_q <= res.rgba;
      out_ok_q   <= res.ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_rgba_q;
  assign m_axis_tuser_o  = out_ok_q;

endmodule

/* sv/csp_checker.sv */
`timescale 1ns / 1ps

module csp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result word changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 32'd0)
    else $error("failed parse with nonzero color");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[31:24] == 8'hFF)
    else $error("good parse without opaque alpha");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while output free");

endmodule

bind color_string_parser_unit csp_checker u_csp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* dv/color_string_checker.sv */
`timescale 1ns / 1ps

module color_string_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          pending_o,
  output int          fail_count_o
);

  localparam int NAMES = 20;
  localparam logic [7:0] HASH_CHAR = "#";

  typedef struct packed {
    logic        ok;
    logic [31:0] rgba;
  } color_t;

  string color_names [NAMES] = '{
    "aqua", "black", "blue", "cyan", "fuchsia", "gray", "green", "grey",
    "lime", "magenta", "maroon", "navy", "olive", "orange", "purple", "red",
    "silver", "teal", "white", "yellow"
  };

  // rrggbb
  logic [23:0] color_rgb [NAMES] = '{
    24'h00FFFF, 24'h000000, 24'h0000FF, 24'h00FFFF, 24'hFF00FF,
    24'h808080, 24'h008000, 24'h808080, 24'h00FF00, 24'hFF00FF,
    24'h800000, 24'h000080, 24'h808000, 24'hFFA500, 24'h800080,
    24'hFF0000, 24'hC0C0C0, 24'h008080, 24'hFFFFFF, 24'hFFFF00
  };

  logic [3:0]       seen_len;
  logic             hash_form;
  logic [23:0]      nibbles;
  logic             bad_digit;
  logic [NAMES-1:0] live_names;

  color_t colors_due [$];
  color_t want;
  int     errors = 0;

  function automatic void clear_string();
    seen_len   = '0;
    hash_form  = 1'b0;
    nibbles    = '0;
    bad_digit  = 1'b0;
    live_names = '1;
  endfunction

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic [7:0] folded;
    logic [4:0] nib;
    folded = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (seen_len == 4'd0 && c == HASH_CHAR) begin
      hash_form = 1'b1;
    end else if (hash_form) begin
      nib = nibble_of(c);
      if (nib[4]) bad_digit = 1'b1;
      nibbles = {nibbles[19:0], nib[3:0]};
    end
    for (int i = 0; i < NAMES; i++) begin
      if (live_names[i] && (seen_len >= color_names[i].len() ||
                            folded != 8'(color_names[i][seen_len]))) begin
        live_names[i] = 1'b0;
      end
    end
    seen_len = (seen_len >= 4'd7) ? 4'd8 : seen_len + 4'd1;
  endfunction

  function automatic color_t pack_rgb(input logic [23:0] rrggbb);
    color_t c;
    c.ok   = 1'b1;
    c.rgba = {8'hFF, rrggbb[7:0], rrggbb[15:8], rrggbb[23:16]};
    return c;
  endfunction

  function automatic color_t finish_string();
    color_t c;
    c = '0;
    if (hash_form) begin
      if (!bad_digit && seen_len == 4'd4) begin
        c = pack_rgb({{2{nibbles[11:8]}}, {2{nibbles[7:4]}}, {2{nibbles[3:0]}}});
      end else if (!bad_digit && seen_len == 4'd7) begin
        c = pack_rgb(nibbles);
      end
    end else begin
      for (int i = 0; i < NAMES; i++) begin
        if (!c.ok && live_names[i] && seen_len == color_names[i].len()) begin
          c = pack_rgb(color_rgb[i]);
        end
      end
    end
    return c;
  endfunction

  function automatic void note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  initial clear_string();

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_string();
      colors_due.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i) begin
          clear_string();
          colors_due.push_back('0);
        end else begin
          take_char(s_tdata_i);
          if (s_tlast_i) begin
            colors_due.push_back(finish_string());
            clear_string();
          end
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (colors_due.size() == 0) begin
          note_fail($sformatf("result word with none expected: rgba %h ok %0b",
                              m_tdata_i, m_tuser_i));
        end else begin
          want = colors_due.pop_front();
          if (m_tdata_i !== want.rgba) begin
            note_fail($sformatf("rgba: expected %h, got %h", want.rgba, m_tdata_i));
          end
          if (m_tuser_i !== want.ok) begin
            note_fail($sformatf("parse_ok: expected %0b, got %0b", want.ok, m_tuser_i));
          end
        end
      end
    end
    pending_o    <= colors_due.size();
    fail_count_o <= errors;
  end

endmodule

/* dv/tb_color_string_parser_unit.sv */
`timescale 1ns / 1ps

module tb_color_string_parser_unit;

  localparam int WORD_TARGET  = 1100;
  localparam int QUIET_WORDS  = 150;
  localparam int PAUSE_AT     = 150;
  localparam int HOLD_START   = 700;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [7:0] HASH_CHAR = "#";

  typedef enum int {
    FORM_NAME,
    FORM_HEX,
    FORM_EMPTY,
    FORM_ABORT,
    FORM_BROKEN,
    FORM_NOISE
  } form_e;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  int pending;
  int fail_count;
  int words_sent = 0;
  int idle_pct   = 30;
  bit quiet      = 1'b0;

  logic [7:0] text_q [$];

  string hue_names [20] = '{
    "aqua", "black", "blue", "cyan", "fuchsia", "gray", "green", "grey",
    "lime", "magenta", "maroon", "navy", "olive", "orange", "purple", "red",
    "silver", "teal", "white", "yellow"
  };

  always #2 clk = ~clk;

  color_string_parser_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  color_string_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1)) return c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return any_case(8'("a" + v - 10));
  endfunction

  function automatic form_e pick_form();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return FORM_NAME;
    if (roll < 55) return FORM_HEX;
    if (roll < 63) return FORM_EMPTY;
    if (roll < 72) return FORM_ABORT;
    if (roll < 88) return FORM_BROKEN;
    return FORM_NOISE;
  endfunction

  task automatic send_word(input logic [7:0] c, input logic end_flag,
                           input logic empty_flag);
    int gap;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= end_flag;
    s_tuser  <= empty_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_queue();
    for (int k = 0; k < text_q.size(); k++) begin
      send_word(text_q[k], k == text_q.size() - 1, 1'b0);
    end
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    send_queue();
  endtask

  task automatic build_name();
    string s;
    s = hue_names[$urandom_range(0, 19)];
    for (int k = 0; k < s.len(); k++) text_q.push_back(any_case(s[k]));
  endtask

  task automatic build_hex();
    int n;
    if ($urandom_range(0, 9) < 7) n = $urandom_range(0, 1) ? 3 : 6;
    else n = $urandom_range(0, 8);
    text_q.push_back(HASH_CHAR);
    repeat (n) text_q.push_back(hex_char());
  endtask

  task automatic build_any();
    if ($urandom_range(0, 1)) build_name();
    else build_hex();
  endtask

  task automatic mutate();
    case ($urandom_range(0, 2))
      0: begin
        text_q[$urandom_range(0, text_q.size() - 1)] =
          ($urandom_range(0, 3) == 0) ? HASH_CHAR : 8'($urandom_range(0, 255));
      end
      1: begin
        if (text_q.size() > 1) void'(text_q.pop_back());
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          text_q.push_back($urandom_range(0, 1) ? hex_char()
                                                : any_case(8'($urandom_range("a", "z"))));
        end
      end
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(8'hFF, 1'b1, 1'b1);
    send_text("#aBc");
    send_text("#09fAeF");
    send_text("rEd");
    send_word(8'h80, 1'b1, 1'b0);
    send_text("#1#");
    send_word("b", 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_text("navyNAVY!");

    while (words_sent < WORD_TARGET) begin
      if (!paused && words_sent >= PAUSE_AT) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        wait_drained();
      end
      quiet = (words_sent >= WORD_TARGET - QUIET_WORDS);
      if ($urandom_range(0, 39) == 0) idle_pct = 30 * $urandom_range(0, 2);
      text_q.delete();
      case (pick_form())
        FORM_NAME: begin
          build_name();
          send_queue();
        end
        FORM_HEX: begin
          build_hex();
          send_queue();
        end
        FORM_EMPTY: begin
          send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
        FORM_ABORT: begin
          build_any();
          repeat ($urandom_range(0, text_q.size() - 1)) void'(text_q.pop_back());
          foreach (text_q[k]) send_word(text_q[k], 1'b0, 1'b0);
          send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
        FORM_BROKEN: begin
          build_any();
          mutate();
          send_queue();
        end
        default: begin
          repeat ($urandom_range(1, 12)) begin
            text_q.push_back(($urandom_range(0, 7) == 0) ? HASH_CHAR
                                                         : 8'($urandom_range(0, 255)));
          end
          send_queue();
        end
      endcase
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("color_string_parser_unit: match");
    end else begin
      $display("color_string_parser_unit: mismatch");
    end
    $finish;
  end

  initial begin : sink
    int cycle_no;
    int gap;
    bit held;
    cycle_no = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && cycle_no >= HOLD_START) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cycle_no += HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        gap = $urandom_range(1, 13);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        cycle_no += gap;
      end
      m_tready <= 1'b1;
      @(posedge clk);
      cycle_no++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("color_string_parser_unit: mismatch");
    $finish;
  end

endmodule
